// ===== hdl/text_mode_terminal_engine_assert.svh =====
// Assertion macros for the text-mode terminal engine.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_MODE_TERMINAL_ENGINE_ASSERT_SVH
`define TEXT_MODE_TERMINAL_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("terminal engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMTE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("terminal engine check failed");

`endif

// ===== hdl/tmte_pkg.sv =====
// Shared types and constants of the text-mode terminal engine.
// Used by the top level.
package tmte_pkg;

  typedef enum logic [2:0] {
    ACT_PUT_CHAR    = 3'd0,
    ACT_MOVE_CURSOR = 3'd1,
    ACT_CURSOR_BACK = 3'd2,
    ACT_COLOR_CELL  = 3'd3,
    ACT_COLOR_ROW   = 3'd4,
    ACT_CLEAR       = 3'd5,
    ACT_READ_CELL   = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CELL_OOB   = 2'd1,
    ST_ROW_OOB    = 2'd2,
    ST_BAD_CURSOR = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_RD_REQ,
    S_RD_DATA,
    S_ADVANCE,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_DONE
  } state_e;

  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0]  CHAR_TAB     = 8'h09;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [3:0]  FG_GREY      = 4'h7;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [3:0]  TAB_STEPS    = 4'd8;

endpackage

// ===== hdl/tmte_if.sv =====
// Request and response channel interfaces of the text-mode terminal engine.
// Depends on nothing; payload widths are fixed by the terminal word format.
interface tmte_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] character;
  logic [3:0] background;
  logic [3:0] foreground;
  logic [7:0] column;
  logic [7:0] line;

  modport source (output valid, action, character, background, foreground, column, line,
                  input ready);
  modport sink (input valid, action, character, background, foreground, column, line,
                output ready);
endinterface

interface tmte_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_column;
  logic [4:0] cursor_line;
  logic [1:0] status;
  logic [7:0] read_character;
  logic [7:0] read_attribute;

  modport source (output valid, cursor_column, cursor_line, status, read_character,
                  read_attribute, input ready);
  modport sink (input valid, cursor_column, cursor_line, status, read_character,
                read_attribute, output ready);
endinterface

// ===== hdl/text_mode_terminal_engine.sv =====
// Text-mode terminal engine top level: sequencer, cursor and result register.
// Depends on tmte_pkg, tmte_if.sv, tmte_cell_ram and the assertion macro header.
//
//   Channel  Dir  Word
//   req_i    in   action, character, background, foreground, column, line
//   rsp_o    out  cursor position, status, read character and attribute
//
// Words are handled one at a time: req_i is ready only while idle. A tab advances the
// cursor by TAB_STEPS cells and can set off a scroll.
// A scroll copies the buffer up one cell at a time, a read and then a write, through
// the single RAM port pair, then blanks the bottom row.
// Colour row fills one row of cells and clear fills every cell of the buffer.
// After reset a clearing pass over every cell runs before req_i is ready.
// A new word is taken while the previous response waits in its output register.
`include "text_mode_terminal_engine_assert.svh"

module text_mode_terminal_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tmte_req_if.sink   req_i,
  tmte_rsp_if.source rsp_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [8:0]    COL_LIMIT  = 9'(COLUMNS);
  localparam logic [8:0]    ROW_LIMIT  = 9'(ROWS);
  localparam logic [AW-1:0] A_COLS     = AW'(COLUMNS);
  localparam logic [AW-1:0] A_LAST     = AW'(CELLS - 1);
  localparam logic [AW-1:0] A_BOTTOM   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] A_SCR_LAST = AW'(CELLS - COLUMNS - 1);

  tmte_pkg::state_e  state_q, state_d, ret_q, ret_d;
  tmte_pkg::action_e act_q, act_d;

  logic [7:0]    chr_q, chr_d;
  logic [3:0]    bg_q, bg_d;
  logic [3:0]    fg_q, fg_d;
  logic [7:0]    col_q, col_d;
  logic [7:0]    row_q, row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [3:0]    steps_q, steps_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] fill_end_q, fill_end_d;
  logic [15:0]   wdata_q, wdata_d;

  tmte_pkg::status_e status_q, status_d;
  logic [7:0]    rd_chr_q, rd_chr_d;
  logic [7:0]    rd_attr_q, rd_attr_d;

  logic          out_valid_q, out_valid_d;
  logic [6:0]    out_col_q, out_col_d;
  logic [4:0]    out_row_q, out_row_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [7:0]    out_chr_q, out_chr_d;
  logic [7:0]    out_attr_q, out_attr_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic          in_range;
  logic          row_ok;
  logic [RW-1:0] mul_row;
  logic [CW-1:0] mul_col;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cell_addr;

  tmte_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_range = ({1'b0, col_q} < COL_LIMIT) && ({1'b0, row_q} < ROW_LIMIT);
  assign row_ok = {1'b0, row_q} < ROW_LIMIT;

  // The one multiplier forms row*COLUMNS for every addressed access.
  assign mul_row   = (act_q == tmte_pkg::ACT_PUT_CHAR) ? cur_row_q : row_q[RW-1:0];
  assign mul_col   = (act_q == tmte_pkg::ACT_PUT_CHAR) ? cur_col_q : col_q[CW-1:0];
  assign row_base  = AW'(mul_row) * A_COLS;
  assign cell_addr = row_base + AW'(mul_col);

  assign req_i.ready = (state_q == tmte_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    act_d        = act_q;
    chr_d        = chr_q;
    bg_d         = bg_q;
    fg_d         = fg_q;
    col_d        = col_q;
    row_d        = row_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    steps_d      = steps_q;
    addr_d       = addr_q;
    ptr_d        = ptr_q;
    fill_end_d   = fill_end_q;
    wdata_d      = wdata_q;
    status_d     = status_q;
    rd_chr_d     = rd_chr_q;
    rd_attr_d    = rd_attr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_status_d = out_status_q;
    out_chr_d    = out_chr_q;
    out_attr_d   = out_attr_q;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q;
    mem_wdata    = wdata_q;
    mem_raddr    = addr_q;

    unique case (state_q)
      tmte_pkg::S_IDLE: begin
        if (req_i.valid) begin
          act_d     = tmte_pkg::action_e'(req_i.action);
          chr_d     = req_i.character;
          bg_d      = req_i.background;
          fg_d      = req_i.foreground;
          col_d     = req_i.column;
          row_d     = req_i.line;
          status_d  = tmte_pkg::ST_OK;
          rd_chr_d  = 8'h00;
          rd_attr_d = 8'h00;
          steps_d   = 4'd0;
          state_d   = tmte_pkg::S_DECODE;
        end
      end

      tmte_pkg::S_DECODE: begin
        addr_d  = cell_addr;
        state_d = tmte_pkg::S_DONE;
        unique case (act_q)
          tmte_pkg::ACT_PUT_CHAR: begin
            if (chr_q == tmte_pkg::CHAR_NEWLINE) begin
              if (cur_row_q == ROW_LAST) begin
                ptr_d   = '0;
                state_d = tmte_pkg::S_SCR_RD;
              end else begin
                cur_col_d = '0;
                cur_row_d = cur_row_q + RW'(1);
              end
            end else if (chr_q == tmte_pkg::CHAR_TAB) begin
              steps_d = tmte_pkg::TAB_STEPS;
              state_d = tmte_pkg::S_ADVANCE;
            end else begin
              wdata_d = {bg_q, fg_q, chr_q};
              steps_d = 4'd1;
              state_d = tmte_pkg::S_WRITE;
            end
          end
          tmte_pkg::ACT_MOVE_CURSOR: begin
            if (in_range) begin
              cur_col_d = col_q[CW-1:0];
              cur_row_d = row_q[RW-1:0];
            end else begin
              status_d = tmte_pkg::ST_BAD_CURSOR;
            end
          end
          tmte_pkg::ACT_CURSOR_BACK: begin
            if (cur_col_q != '0) begin
              cur_col_d = cur_col_q - CW'(1);
            end else if (cur_row_q != '0) begin
              cur_row_d = cur_row_q - RW'(1);
              cur_col_d = COL_LAST;
            end
          end
          tmte_pkg::ACT_COLOR_CELL: begin
            if (in_range) begin
              wdata_d = {bg_q, tmte_pkg::FG_GREY, tmte_pkg::CHAR_SPACE};
              state_d = tmte_pkg::S_WRITE;
            end else begin
              status_d = tmte_pkg::ST_CELL_OOB;
            end
          end
          tmte_pkg::ACT_COLOR_ROW: begin
            if (row_ok) begin
              ptr_d      = row_base;
              fill_end_d = row_base + A_COLS - AW'(1);
              wdata_d    = {bg_q, tmte_pkg::FG_GREY, tmte_pkg::CHAR_SPACE};
              ret_d      = tmte_pkg::S_DONE;
              state_d    = tmte_pkg::S_FILL;
            end else begin
              status_d = tmte_pkg::ST_ROW_OOB;
            end
          end
          tmte_pkg::ACT_CLEAR: begin
            cur_col_d  = '0;
            cur_row_d  = '0;
            ptr_d      = '0;
            fill_end_d = A_LAST;
            wdata_d    = tmte_pkg::BLANK_CELL;
            ret_d      = tmte_pkg::S_DONE;
            state_d    = tmte_pkg::S_FILL;
          end
          tmte_pkg::ACT_READ_CELL: begin
            if (in_range) begin
              state_d = tmte_pkg::S_RD_REQ;
            end else begin
              status_d = tmte_pkg::ST_CELL_OOB;
            end
          end
          default: begin
            state_d = tmte_pkg::S_DONE;
          end
        endcase
      end

      tmte_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        state_d   = tmte_pkg::S_ADVANCE;
      end

      tmte_pkg::S_RD_REQ: begin
        state_d = tmte_pkg::S_RD_DATA;
      end

      tmte_pkg::S_RD_DATA: begin
        rd_chr_d  = mem_rdata[7:0];
        rd_attr_d = mem_rdata[15:8];
        state_d   = tmte_pkg::S_DONE;
      end

      tmte_pkg::S_ADVANCE: begin
        if (steps_q == 4'd0) begin
          state_d = tmte_pkg::S_DONE;
        end else begin
          steps_d = steps_q - 4'd1;
          if (cur_col_q != COL_LAST) begin
            cur_col_d = cur_col_q + CW'(1);
          end else if (cur_row_q != ROW_LAST) begin
            cur_col_d = '0;
            cur_row_d = cur_row_q + RW'(1);
          end else begin
            ptr_d   = '0;
            state_d = tmte_pkg::S_SCR_RD;
          end
        end
      end

      tmte_pkg::S_SCR_RD: begin
        mem_raddr = ptr_q + A_COLS;
        state_d   = tmte_pkg::S_SCR_WR;
      end

      tmte_pkg::S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_q == A_SCR_LAST) begin
          ptr_d      = A_BOTTOM;
          fill_end_d = A_LAST;
          wdata_d    = tmte_pkg::BLANK_CELL;
          cur_col_d  = '0;
          cur_row_d  = ROW_LAST;
          ret_d      = tmte_pkg::S_ADVANCE;
          state_d    = tmte_pkg::S_FILL;
        end else begin
          ptr_d   = ptr_q + AW'(1);
          state_d = tmte_pkg::S_SCR_RD;
        end
      end

      tmte_pkg::S_FILL: begin
        mem_we = 1'b1;
        if (ptr_q == fill_end_q) begin
          state_d = ret_q;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      tmte_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_col_d    = 7'(cur_col_q);
          out_row_d    = 5'(cur_row_q);
          out_status_d = status_q;
          out_chr_d    = rd_chr_q;
          out_attr_d   = rd_attr_q;
          state_d      = tmte_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tmte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmte_pkg::S_FILL;
      ret_q       <= tmte_pkg::S_IDLE;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      steps_q     <= 4'd0;
      ptr_q       <= '0;
      fill_end_q  <= A_LAST;
      wdata_q     <= tmte_pkg::BLANK_CELL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      steps_q     <= steps_d;
      ptr_q       <= ptr_d;
      fill_end_q  <= fill_end_d;
      wdata_q     <= wdata_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    chr_q        <= chr_d;
    bg_q         <= bg_d;
    fg_q         <= fg_d;
    col_q        <= col_d;
    row_q        <= row_d;
    addr_q       <= addr_d;
    status_q     <= status_d;
    rd_chr_q     <= rd_chr_d;
    rd_attr_q    <= rd_attr_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
    out_status_q <= out_status_d;
    out_chr_q    <= out_chr_d;
    out_attr_q   <= out_attr_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cursor_column  = out_col_q;
  assign rsp_o.cursor_line    = out_row_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.read_character = out_chr_q;
  assign rsp_o.read_attribute = out_attr_q;

  `TMTE_ASSERT_IMP(a_cursor_legal, 1'b1, (cur_col_q <= COL_LAST) && (cur_row_q <= ROW_LAST))
  `TMTE_ASSERT_IMP(a_scroll_in_range, state_q == tmte_pkg::S_SCR_RD, ptr_q <= A_SCR_LAST)
  `TMTE_ASSERT_IMP(a_steps_bounded, 1'b1, steps_q <= tmte_pkg::TAB_STEPS)
  `TMTE_ASSERT_NXT(a_done_delivers, state_q == tmte_pkg::S_DONE && !out_valid_q, out_valid_q)

endmodule

// ===== hdl/tmte_cell_ram.sv =====
// Character cell buffer: one write port and one registered read port.
// Depends on nothing; the sequencer in the top level drives both ports.
module tmte_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
